/* sv/lcdnib_pkg.sv */
// shared types, constants and helpers of the 4-bit character lcd controller
package lcdnib_pkg;

  localparam int unsigned DelayWidth  = 20;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [2:0] InitDone    = 3'd5;
  localparam logic [1:0] RawRepeats  = 2'd3;
  localparam logic [3:0] RawNibble   = 4'h3;
  localparam logic [3:0] FinalNibble = 4'h2;

  typedef enum logic [2:0] {
    StInitWait,
    StInitPulse,
    StHiPulse,
    StHiWait,
    StLoPulse,
    StLoWait,
    StClearWait,
    StIdle
  } step_e;

  typedef enum logic [1:0] {
    ModeTick,
    ModeWrite,
    ModeRestart
  } mode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgEnablePulse,
    CfgAfterNibble,
    CfgInitWait,
    CfgInitPulse,
    CfgClearWait
  } cfg_idx_e;

  typedef struct packed {
    logic [DelayWidth-1:0] enable_pulse;
    logic [DelayWidth-1:0] after_nibble;
    logic [DelayWidth-1:0] init_wait;
    logic [DelayWidth-1:0] init_pulse;
    logic [DelayWidth-1:0] clear_wait;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic       to_data_register;
  } item_t;

  typedef struct packed {
    logic       e;
    logic       rs;
    logic [3:0] nib;
  } pins_t;

  typedef struct packed {
    pins_t pins;
    logic  busy;
    logic  accepted;
  } res_t;

  // power-up command list, sent after the raw nibbles
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      3'd0:    cmd = 8'h28;
      3'd1:    cmd = 8'h08;
      3'd2:    cmd = 8'h01;
      3'd3:    cmd = 8'h06;
      3'd4:    cmd = 8'h0C;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

  // length of a step in ticks, a zero register counts as one tick
  function automatic logic [DelayWidth-1:0] step_len(input step_e st, input cfg_t cfg);
    logic [DelayWidth-1:0] len;
    unique case (st)
      StInitWait:             len = cfg.init_wait;
      StInitPulse:            len = cfg.init_pulse;
      StHiPulse, StLoPulse:   len = cfg.enable_pulse;
      StHiWait, StLoWait:     len = cfg.after_nibble;
      StClearWait:            len = cfg.clear_wait;
      default:                len = DelayWidth'(1);
    endcase
    if (len == '0) begin
      len = DelayWidth'(1);
    end
    return len;
  endfunction

endpackage

/* sv/lcdnib_if.sv */
// channel interfaces: request items, result items and register writes
interface lcdnib_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] byte_value;
  logic       to_data_register;

  modport source (output valid, mode, byte_value, to_data_register, input ready);
  modport sink (input valid, mode, byte_value, to_data_register, output ready);
endinterface

interface lcdnib_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble_pins;
  logic       register_select;
  logic       enable_pin;
  logic       busy_res;
  logic       accepted;

  modport source (output valid, nibble_pins, register_select, enable_pin, busy_res, accepted,
                  input ready);
  modport sink (input valid, nibble_pins, register_select, enable_pin, busy_res, accepted,
                output ready);
endinterface

interface lcdnib_cfg_if;
  import lcdnib_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxWidth-1:0] index;
  logic [DelayWidth-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/lcdnib_cfg.sv */
// timing register file
module lcdnib_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcdnib_cfg_if.sink          cfg_ch,
  output lcdnib_pkg::cfg_t    cfg_o
);
  import lcdnib_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_e'(cfg_ch.index))
        CfgEnablePulse: cfg_d.enable_pulse = cfg_ch.data;
        CfgAfterNibble: cfg_d.after_nibble = cfg_ch.data;
        CfgInitWait:    cfg_d.init_wait    = cfg_ch.data;
        CfgInitPulse:   cfg_d.init_pulse   = cfg_ch.data;
        CfgClearWait:   cfg_d.clear_wait   = cfg_ch.data;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_pulse <= DelayWidth'(400);
      cfg_q.after_nibble <= DelayWidth'(14000);
      cfg_q.init_wait    <= DelayWidth'(500000);
      cfg_q.init_pulse   <= DelayWidth'(10000);
      cfg_q.clear_wait   <= DelayWidth'(10000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/lcdnib_seq.sv */
// init and byte-write sequencer, one item per call
module lcdnib_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  lcdnib_pkg::item_t  item_i,
  input  lcdnib_pkg::cfg_t   cfg_i,
  output lcdnib_pkg::res_t   res_o
);
  import lcdnib_pkg::*;

  step_e                 step_q, step_d;
  logic [DelayWidth-1:0] cnt_q, cnt_d;
  logic [7:0]            byte_q, byte_d;
  logic                  sel_q, sel_d;
  logic [2:0]            idx_q, idx_d;
  logic [1:0]            raw_q, raw_d;
  pins_t                 pins_q, pins_d;

  logic [DelayWidth:0]   cnt_inc;
  logic                  step_done;
  logic                  idle;

  // command bytes that can start next
  logic [7:0]            cmd_first;
  logic [7:0]            cmd_next;
  logic [7:0]            cmd_after_clear;

  assign idle      = (step_q == StIdle);
  assign cnt_inc   = {1'b0, cnt_q} + (DelayWidth+1)'(1);
  assign step_done = cnt_inc >= {1'b0, step_len(step_q, cfg_i)};

  assign cmd_first       = init_cmd(3'd0);
  assign cmd_next        = init_cmd(idx_q + 3'd1);
  assign cmd_after_clear = init_cmd(3'd3);

  // next state
  always_comb begin
    step_d = step_q;
    cnt_d  = cnt_q;
    byte_d = byte_q;
    sel_d  = sel_q;
    idx_d  = idx_q;
    raw_d  = raw_q;
    pins_d = pins_q;
    if (fire_i) begin
      unique case (item_i.mode)
        ModeTick: begin
          if (!idle) begin
            if (step_done) begin
              cnt_d = '0;
              unique case (step_q)
                StInitWait: begin
                  pins_d = '{e: 1'b1, rs: 1'b0,
                             nib: (raw_q < RawRepeats) ? RawNibble : FinalNibble};
                  step_d = StInitPulse;
                end
                StInitPulse: begin
                  if (raw_q >= RawRepeats) begin
                    idx_d  = '0;
                    byte_d = cmd_first;
                    sel_d  = 1'b0;
                    pins_d = '{e: 1'b1, rs: 1'b0, nib: cmd_first[7:4]};
                    step_d = StHiPulse;
                  end else begin
                    pins_d.e = 1'b0;
                    raw_d    = raw_q + 2'd1;
                    step_d   = StInitWait;
                  end
                end
                StHiPulse: begin
                  pins_d.e = 1'b0;
                  step_d   = StHiWait;
                end
                StHiWait: begin
                  pins_d = '{e: 1'b1, rs: sel_q, nib: byte_q[3:0]};
                  step_d = StLoPulse;
                end
                StLoPulse: begin
                  pins_d.e = 1'b0;
                  step_d   = StLoWait;
                end
                StLoWait: begin
                  if (idx_q < InitDone) begin
                    if (idx_q == 3'd2) begin
                      // clear display needs its own extra wait
                      idx_d  = 3'd3;
                      step_d = StClearWait;
                    end else begin
                      idx_d = idx_q + 3'd1;
                      if (idx_q + 3'd1 < InitDone) begin
                        byte_d = cmd_next;
                        sel_d  = 1'b0;
                        pins_d = '{e: 1'b1, rs: 1'b0, nib: cmd_next[7:4]};
                        step_d = StHiPulse;
                      end else begin
                        step_d = StIdle;
                      end
                    end
                  end else begin
                    step_d = StIdle;
                  end
                end
                StClearWait: begin
                  byte_d = cmd_after_clear;
                  sel_d  = 1'b0;
                  pins_d = '{e: 1'b1, rs: 1'b0, nib: cmd_after_clear[7:4]};
                  step_d = StHiPulse;
                end
                default: step_d = StIdle;
              endcase
            end else begin
              cnt_d = cnt_inc[DelayWidth-1:0];
            end
          end
        end
        ModeWrite: begin
          if (idle) begin
            byte_d = item_i.byte_value;
            sel_d  = item_i.to_data_register;
            cnt_d  = '0;
            pins_d = '{e: 1'b1, rs: item_i.to_data_register, nib: item_i.byte_value[7:4]};
            step_d = StHiPulse;
          end
        end
        ModeRestart: begin
          if (idle) begin
            step_d   = StInitWait;
            cnt_d    = '0;
            raw_d    = '0;
            idx_d    = '0;
            pins_d.e = 1'b0;
          end
        end
        default: step_d = step_q;
      endcase
    end
  end

  // result of the item
  always_comb begin
    res_o.pins     = pins_d;
    res_o.busy     = (step_d != StIdle);
    res_o.accepted = idle && ((item_i.mode == ModeWrite) || (item_i.mode == ModeRestart));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StInitWait;
      cnt_q  <= '0;
      byte_q <= '0;
      sel_q  <= 1'b0;
      idx_q  <= '0;
      raw_q  <= '0;
      pins_q <= '0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
      byte_q <= byte_d;
      sel_q  <= sel_d;
      idx_q  <= idx_d;
      raw_q  <= raw_d;
      pins_q <= pins_d;
    end
  end

  a_idle_e_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == StIdle |-> !pins_q.e)
    else $error("enable high while idle");

  a_no_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(step_q) && $stable(cnt_q) && $stable(pins_q))
    else $error("state moved without an item");

  a_write_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.mode == ModeWrite && step_q == StIdle |=> step_q == StHiPulse && pins_q.e)
    else $error("taken write did not start high nibble");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= InitDone)
    else $error("init command index out of range");

endmodule

/* sv/char_lcd_nibble_interface.sv */
// top level of the 4-bit character lcd controller
//
// channel   direction  beat contents
// in_ch     sink       mode, byte_value, to_data_register
// out_ch    source     nibble_pins, register_select, enable_pin, busy_res, accepted
// cfg_ch    sink       index (0..4 timing register), data (20 bit tick count)
//
// one beat in gives exactly one beat out, one beat per cycle sustained while the output does not stall
// a beat passes through the input register, then the sequencer step into the result register
// after reset the power-up sequence is armed and advances with tick beats
// an output stall holds the result register, the input register still takes one beat
// register writes are taken every cycle, ready is always high
module char_lcd_nibble_interface (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcdnib_in_if.sink   in_ch,
  lcdnib_out_if.source out_ch,
  lcdnib_cfg_if.sink  cfg_ch
);
  import lcdnib_pkg::*;

  // input register
  item_t in_q;
  logic  in_valid_q;

  // result register
  res_t  out_q;
  logic  out_valid_q;

  cfg_t  cfg;
  res_t  res;
  logic  advance;

  // an item moves into the sequencer when the result slot is free or draining
  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_q <= '{mode: in_ch.mode, byte_value: in_ch.byte_value,
                to_data_register: in_ch.to_data_register};
    end
  end

  lcdnib_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  lcdnib_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.nibble_pins     = out_q.pins.nib;
  assign out_ch.register_select = out_q.pins.rs;
  assign out_ch.enable_pin      = out_q.pins.e;
  assign out_ch.busy_res        = out_q.busy;
  assign out_ch.accepted        = out_q.accepted;

endmodule

/* bench/lcdnib_checker.sv */
`timescale 1ns / 1ps
// watches the three channels, predicts every result beat and compares it field by field
module lcdnib_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  lcdnib_in_if         in_ch,
  lcdnib_out_if        out_ch,
  lcdnib_cfg_if        cfg_ch,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o,
  output logic         lcd_busy_o,
  output int unsigned  results_o,
  output int unsigned  bytes_o,
  output int unsigned  restarts_o
);
  import lcdnib_pkg::*;

  // command bytes of the power-up sequence, element 0 goes first
  localparam logic [4:0][7:0] PowerUpCmds = {8'h0C, 8'h06, 8'h01, 8'h08, 8'h28};
  localparam logic [2:0] ClearCmdIdx   = 3'd2;
  localparam logic [2:0] AfterClearIdx = 3'd3;

  cfg_t        timing;
  step_e       lcd_step;
  int unsigned step_ticks;
  logic [7:0]  byte_q;
  logic        rs_q;
  logic [2:0]  cmd_idx;
  logic [1:0]  raw_sent;
  pins_t       pins;
  res_t        expected_q[$];

  function automatic int unsigned ticks_for(input step_e st);
    logic [DelayWidth-1:0] n;
    case (st)
      StInitWait:           n = timing.init_wait;
      StInitPulse:          n = timing.init_pulse;
      StHiPulse, StLoPulse: n = timing.enable_pulse;
      StHiWait, StLoWait:   n = timing.after_nibble;
      StClearWait:          n = timing.clear_wait;
      default:              n = DelayWidth'(1);
    endcase
    // a zero register behaves as a single tick
    return (n == '0) ? 1 : n;
  endfunction

  function automatic void put_nibble(input logic [3:0] nib, input logic rs);
    pins.nib = nib;
    pins.rs  = rs;
    pins.e   = 1'b1;
  endfunction

  function automatic void start_byte(input logic [7:0] value, input logic rs);
    byte_q     = value;
    rs_q       = rs;
    lcd_step   = StHiPulse;
    step_ticks = 0;
    put_nibble(value[7:4], rs);
  endfunction

  function automatic void start_power_up();
    lcd_step   = StInitWait;
    step_ticks = 0;
    raw_sent   = '0;
    cmd_idx    = '0;
    pins.e     = 1'b0;
  endfunction

  function automatic void end_step();
    step_ticks = 0;
    case (lcd_step)
      StInitWait: begin
        put_nibble((raw_sent < RawRepeats) ? RawNibble : FinalNibble, 1'b0);
        lcd_step = StInitPulse;
      end
      StInitPulse: begin
        pins.e = 1'b0;
        if (raw_sent >= RawRepeats) begin
          cmd_idx = '0;
          start_byte(PowerUpCmds[0], 1'b0);
        end else begin
          raw_sent = raw_sent + 2'd1;
          lcd_step = StInitWait;
        end
      end
      StHiPulse: begin
        pins.e   = 1'b0;
        lcd_step = StHiWait;
      end
      StHiWait: begin
        put_nibble(byte_q[3:0], rs_q);
        lcd_step = StLoPulse;
      end
      StLoPulse: begin
        pins.e   = 1'b0;
        lcd_step = StLoWait;
      end
      StLoWait: begin
        if (cmd_idx < InitDone) begin
          if (cmd_idx == ClearCmdIdx) begin
            // the clear command gets an extra wait of its own
            cmd_idx  = AfterClearIdx;
            lcd_step = StClearWait;
          end else begin
            cmd_idx = cmd_idx + 3'd1;
            if (cmd_idx < InitDone) begin
              start_byte(PowerUpCmds[cmd_idx], 1'b0);
            end else begin
              lcd_step = StIdle;
            end
          end
        end else begin
          lcd_step = StIdle;
        end
      end
      StClearWait: begin
        start_byte(PowerUpCmds[AfterClearIdx], 1'b0);
      end
      default: begin
        lcd_step = StIdle;
      end
    endcase
  endfunction

  function automatic void take_write();
    case (cfg_ch.index)
      CfgEnablePulse: timing.enable_pulse = cfg_ch.data;
      CfgAfterNibble: timing.after_nibble = cfg_ch.data;
      CfgInitWait:    timing.init_wait    = cfg_ch.data;
      CfgInitPulse:   timing.init_pulse   = cfg_ch.data;
      CfgClearWait:   timing.clear_wait   = cfg_ch.data;
      default: ;
    endcase
  endfunction

  function automatic void predict_beat();
    res_t want;
    logic taken;
    logic idle;
    taken = 1'b0;
    idle  = (lcd_step == StIdle);
    case (in_ch.mode)
      ModeTick: begin
        if (!idle) begin
          if (step_ticks + 1 >= ticks_for(lcd_step)) begin
            end_step();
          end else begin
            step_ticks++;
          end
        end
      end
      ModeWrite: begin
        if (idle) begin
          start_byte(in_ch.byte_value, in_ch.to_data_register);
          taken = 1'b1;
          bytes_o++;
        end
      end
      ModeRestart: begin
        if (idle) begin
          start_power_up();
          taken = 1'b1;
          restarts_o++;
        end
      end
      default: ;
    endcase
    want.pins     = pins;
    want.busy     = (lcd_step != StIdle);
    want.accepted = taken;
    expected_q.push_back(want);
    pending_o++;
    lcd_busy_o = want.busy;
  endfunction

  function automatic void check_beat();
    res_t want;
    if (expected_q.size() == 0) begin
      $error("result beat arrived with no request waiting");
      fail_count_o++;
      return;
    end
    want = expected_q.pop_front();
    pending_o--;
    results_o++;
    if (out_ch.nibble_pins !== want.pins.nib) begin
      $error("nibble_pins: expected %h, got %h", want.pins.nib, out_ch.nibble_pins);
      fail_count_o++;
    end
    if (out_ch.register_select !== want.pins.rs) begin
      $error("register_select: expected %b, got %b", want.pins.rs, out_ch.register_select);
      fail_count_o++;
    end
    if (out_ch.enable_pin !== want.pins.e) begin
      $error("enable_pin: expected %b, got %b", want.pins.e, out_ch.enable_pin);
      fail_count_o++;
    end
    if (out_ch.busy_res !== want.busy) begin
      $error("busy_res: expected %b, got %b", want.busy, out_ch.busy_res);
      fail_count_o++;
    end
    if (out_ch.accepted !== want.accepted) begin
      $error("accepted: expected %b, got %b", want.accepted, out_ch.accepted);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing.enable_pulse = DelayWidth'(400);
      timing.after_nibble = DelayWidth'(14000);
      timing.init_wait    = DelayWidth'(500000);
      timing.init_pulse   = DelayWidth'(10000);
      timing.clear_wait   = DelayWidth'(10000);
      byte_q = '0;
      rs_q   = 1'b0;
      pins   = '0;
      start_power_up();
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      bytes_o      = 0;
      restarts_o   = 0;
      lcd_busy_o   = 1'b1;
    end else begin
      // registers first, then the request beat, then the result beat
      if (cfg_ch.valid && cfg_ch.ready) take_write();
      if (in_ch.valid && in_ch.ready) predict_beat();
      if (out_ch.valid && out_ch.ready) check_beat();
    end
  end

endmodule

/* bench/tb_char_lcd_nibble_interface.sv */
`timescale 1ns / 1ps
// testbench top: clock, reset, request and register stimulus, output idling and verdict
module tb_char_lcd_nibble_interface;
  import lcdnib_pkg::*;

  // the one mode code the block leaves unused
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [DelayWidth-1:0] MaxTicks = '1;

  localparam int unsigned PhaseItems    = 320;
  localparam int unsigned HoldOffCycles = 300;
  // covers the input and result registers of the top level, plus margin
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned DrainLimit    = 50000;
  localparam int unsigned WatchdogNs    = 5000000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lcdnib_in_if  in_ch ();
  lcdnib_out_if out_ch ();
  lcdnib_cfg_if cfg_ch ();

  // idling knobs, in percent of cycles
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  // one-shot request for a long output hold-off
  logic        hold_req       = 1'b0;

  int unsigned mismatches;
  int unsigned waiting;
  logic        lcd_busy;
  int unsigned beats_checked;
  int unsigned bytes_taken;
  int unsigned restarts_taken;

  always #5 clk_i = ~clk_i;

  char_lcd_nibble_interface dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lcdnib_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count_o (mismatches),
    .pending_o    (waiting),
    .lcd_busy_o   (lcd_busy),
    .results_o    (beats_checked),
    .bytes_o      (bytes_taken),
    .restarts_o   (restarts_taken)
  );

  // result side: random stalls, and on request one long hold-off counted here
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    #(WatchdogNs);
    $error("timeout: run did not complete");
    $display("*** FAILED ***");
    $finish;
  end

  // offer one request beat; called at a falling edge, returns at the falling edge after
  // acceptance with valid still high so back-to-back beats need no extra assignment
  task automatic send_beat(input logic [1:0] mode, input logic [7:0] value, input logic rs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.mode             <= mode;
    in_ch.byte_value       <= value;
    in_ch.to_data_register <= rs;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one register write beat, same calling convention as send_beat
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [DelayWidth-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // full timing set, preceded by writes to every index the block does not decode
  task automatic write_timing(input cfg_t t);
    for (int i = int'(CfgClearWait) + 1; i < (1 << CfgIdxWidth); i++) begin
      write_reg(i[CfgIdxWidth-1:0], DelayWidth'($urandom));
    end
    write_reg(CfgEnablePulse, t.enable_pulse);
    write_reg(CfgAfterNibble, t.after_nibble);
    write_reg(CfgInitWait,    t.init_wait);
    write_reg(CfgInitPulse,   t.init_pulse);
    write_reg(CfgClearWait,   t.clear_wait);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop offering and wait for every predicted beat, then let the pipeline settle
  task automatic drain();
    int unsigned spent;
    spent = 0;
    in_ch.valid <= 1'b0;
    while (waiting != 0 && spent < DrainLimit) begin
      @(negedge clk_i);
      spent++;
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic cfg_t random_timing(input int unsigned top);
    cfg_t t;
    t.enable_pulse = DelayWidth'($urandom_range(0, top));
    t.after_nibble = DelayWidth'($urandom_range(0, top));
    t.init_wait    = DelayWidth'($urandom_range(0, top));
    t.init_pulse   = DelayWidth'($urandom_range(0, top));
    t.clear_wait   = DelayWidth'($urandom_range(0, top));
    return t;
  endfunction

  // tick the sequencer until the predicted state is idle
  task automatic tick_until_idle();
    while (lcd_busy) send_beat(ModeTick, 8'($urandom), 1'($urandom));
  endtask

  // mostly well-formed traffic: requests when idle, ticks while busy, a little noise
  task automatic random_beat(input bit allow_restart);
    int unsigned r;
    logic [1:0]  mode;
    r = $urandom_range(99);
    if (!lcd_busy) begin
      if (r < 70) mode = ModeWrite;
      else if (r < 80 && allow_restart) mode = ModeRestart;
      else if (r < 90) mode = ModeTick;
      else mode = ModeUnused;
    end else begin
      // requests here are refused since the block is busy
      if (r < 85) mode = ModeTick;
      else if (r < 90) mode = ModeWrite;
      else if (r < 95) mode = ModeRestart;
      else mode = ModeUnused;
    end
    send_beat(mode, 8'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(input int unsigned src, input int unsigned sink, input cfg_t t,
                           input bit allow_restart, input bit hold_off);
    drain();
    write_timing(t);
    src_idle_pct   = src;
    sink_stall_pct = sink;
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      // long output hold-off while requests keep coming, so the block backs up
      if (hold_off && i == PhaseItems / 4) hold_req = 1'b1;
      random_beat(allow_restart);
    end
  endtask

  initial begin : stimulus
    in_ch.valid            = 1'b0;
    in_ch.mode             = ModeTick;
    in_ch.byte_value       = '0;
    in_ch.to_data_register = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = CfgEnablePulse;
    cfg_ch.data            = '0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // shrink the power-up timing before any tick; zero registers act as one tick
    write_timing('{DelayWidth'(0), DelayWidth'(1), DelayWidth'(1), DelayWidth'(0),
                   DelayWidth'(1)});

    // requests during power-up are refused, unused mode is ignored
    send_beat(ModeWrite, 8'hFF, 1'b1);
    send_beat(ModeRestart, 8'h00, 1'b0);
    send_beat(ModeUnused, 8'hFF, 1'b1);
    tick_until_idle();
    // command byte of all zeros, then a write that lands while busy
    send_beat(ModeWrite, 8'h00, 1'b0);
    send_beat(ModeWrite, 8'h12, 1'b1);
    tick_until_idle();
    send_beat(ModeWrite, 8'hFF, 1'b1);
    tick_until_idle();
    send_beat(ModeWrite, 8'hA5, 1'b1);
    tick_until_idle();
    send_beat(ModeWrite, 8'h5A, 1'b0);
    tick_until_idle();
    // ticks and unused mode while idle change nothing
    send_beat(ModeTick, 8'hC3, 1'b1);
    send_beat(ModeUnused, 8'h00, 1'b0);
    // restart keeps the pins but drops E, then the whole sequence runs again
    send_beat(ModeRestart, 8'h3C, 1'b1);
    tick_until_idle();

    run_phase(0, 0, random_timing(6), 1'b1, 1'b0);
    run_phase(81, 0, random_timing(6), 1'b1, 1'b0);
    run_phase(0, 81, random_timing(6), 1'b1, 1'b0);
    run_phase(38, 38, random_timing(8), 1'b1, 1'b1);

    // top of range on every register, then byte writes only: power-up steps stay at max
    drain();
    write_timing('{MaxTicks, MaxTicks, MaxTicks, MaxTicks, MaxTicks});
    run_phase(0, 0, '{DelayWidth'(1), DelayWidth'(2), MaxTicks, MaxTicks, MaxTicks},
              1'b0, 1'b0);

    run_phase(38, 38, random_timing(3), 1'b1, 1'b0);

    drain();
    if (waiting != 0) begin
      $error("%0d result beats never arrived", waiting);
    end
    $display("checked %0d result beats: %0d bytes and %0d restarts taken",
             beats_checked, bytes_taken, restarts_taken);
    $display("timing from zero ticks to the register maximum, idle, stall and hold-off phases");
    if (mismatches == 0 && waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lcdnib_pkg.sv
sv/lcdnib_if.sv
sv/lcdnib_cfg.sv
sv/lcdnib_seq.sv
sv/char_lcd_nibble_interface.sv
bench/lcdnib_checker.sv
bench/tb_char_lcd_nibble_interface.sv
